/* src/scba_pkg.sv */
package scba_pkg;

  localparam int CMD_W    = 2;
  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 20;
  localparam int STATUS_W = 2;

  // stream packing: size then address in tdata, command in tuser
  localparam int S_TDATA_W = 40;
  localparam int SIZE_LSB  = 0;
  localparam int ADDR_LSB  = SIZE_LSB + SIZE_W;
  localparam int M_TDATA_W = 24;

  localparam int TABLE_LEN    = 14;
  localparam int CLS_W        = 4;
  localparam int CLS_BYTES_W  = 10;
  localparam int SLOT_SHIFT   = 4;
  localparam int LINK_AW      = ADDR_W - SLOT_SHIFT;
  localparam int LINK_DEPTH   = 1 << LINK_AW;
  localparam int LINK_W       = ADDR_W + 1;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CLS_BYTES_W-1:0] CLASS_BYTES [TABLE_LEN] = '{
    10'd16, 10'd32, 10'd64, 10'd96, 10'd128, 10'd160, 10'd192,
    10'd224, 10'd256, 10'd320, 10'd384, 10'd448, 10'd512, 10'd640
  };

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NULL     = 2'd1,
    STATUS_OVERSIZE = 2'd2,
    STATUS_NO_CHUNK = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_REPLY = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CLS_W-1:0]  cls;
    logic [ADDR_W-1:0] address;
    status_e           status;
  } job_t;

endpackage

/* src/size_class_block_allocator.sv */
// Items pass the queue stage, then the result register, before their result is valid.
// Throughput: 1 item per cycle for free, clear, carve and chunk opening while the output
// is not stalled; a free-list allocation blocks the next item until the link read lands.
// Reset (asynchronous, active low) empties all lists, chunks and the queue at once;
// the link memory is not cleared and needs no clearing pass.
module size_class_block_allocator import scba_pkg::*; #(
  parameter int MAX_CHUNKS   = 64,
  parameter int CHUNK_BYTES  = 16384,
  parameter int MAX_BLOCK    = 640,
  parameter int SIZE_CLASSES = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // size[15:0], address[35:16]
  input  logic [CMD_W-1:0]     s_axis_tuser_i,  // command[1:0]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,  // block_address[19:0]
  output logic [STATUS_W-1:0]  m_axis_tuser_o   // status[1:0]
);

  logic              fr_valid, fr_ready;
  job_t              fr_job;
  logic              bk_valid, bk_ready;
  job_t              bk_job;
  logic [ADDR_W-1:0] out_addr;

  scba_front #(
    .MAX_BLOCK    (MAX_BLOCK),
    .SIZE_CLASSES (SIZE_CLASSES)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .job_valid_o     (fr_valid),
    .job_ready_i     (fr_ready),
    .job_o           (fr_job)
  );

  scba_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_job_i   (fr_job),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_job_o    (bk_job)
  );

  scba_back #(
    .MAX_CHUNKS   (MAX_CHUNKS),
    .CHUNK_BYTES  (CHUNK_BYTES),
    .SIZE_CLASSES (SIZE_CLASSES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (bk_valid),
    .job_ready_o  (bk_ready),
    .job_i        (bk_job),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_addr_o   (out_addr),
    .out_status_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(M_TDATA_W - ADDR_W){1'b0}}, out_addr};

endmodule

/* src/scba_ram.sv */
module scba_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/scba_front.sv */
module scba_front import scba_pkg::*; #(
  parameter int MAX_BLOCK    = 640,
  parameter int SIZE_CLASSES = 14
) (
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic [CMD_W-1:0]     s_axis_tuser_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output job_t                 job_o
);

  logic [SIZE_W-1:0] size;
  logic [CLS_W-1:0]  cls;
  logic              hit;

  assign size = s_axis_tdata_i[SIZE_LSB +: SIZE_W];

  // smallest enabled class that holds the size
  always_comb begin
    cls = '0;
    hit = 1'b0;
    for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
      if (size <= SIZE_W'(CLASS_BYTES[i])) begin
        cls = CLS_W'(i);
        hit = 1'b1;
      end
    end
    if (size > SIZE_W'(MAX_BLOCK)) begin
      hit = 1'b0;
    end
  end

  always_comb begin
    job_o.cls     = cls;
    job_o.address = s_axis_tdata_i[ADDR_LSB +: ADDR_W];
    job_o.status  = STATUS_OK;
    job_o.op      = OP_REPLY;
    case (s_axis_tuser_i)
      CMD_ALLOC, CMD_FREE: begin
        if (size == '0) begin
          job_o.status = STATUS_NULL;
        end else if (!hit) begin
          job_o.status = STATUS_OVERSIZE;
        end else begin
          job_o.op = (s_axis_tuser_i == CMD_ALLOC) ? OP_ALLOC : OP_FREE;
        end
      end
      CMD_CLEAR: job_o.op = OP_CLEAR;
      default:   job_o.op = OP_REPLY;
    endcase
  end

  assign job_valid_o     = s_axis_tvalid_i;
  assign s_axis_tready_o = job_ready_i;

endmodule

/* src/scba_queue.sv */
module scba_queue import scba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            slots_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

/* src/scba_back.sv */
module scba_back import scba_pkg::*; #(
  parameter int MAX_CHUNKS   = 64,
  parameter int CHUNK_BYTES  = 16384,
  parameter int SIZE_CLASSES = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  job_t                job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ADDR_W-1:0]   out_addr_o,
  output logic [STATUS_W-1:0] out_status_o
);

  localparam int ClsW  = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int LeftW = $clog2(CHUNK_BYTES / 16);
  localparam int UsedW = $clog2(MAX_CHUNKS + 1);
  localparam logic [ADDR_W-1:0] ChunkStep = ADDR_W'(CHUNK_BYTES);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_POP = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [LINK_W-1:0] heads_q [SIZE_CLASSES];
  logic [LINK_W-1:0] heads_d [SIZE_CLASSES];
  logic [ADDR_W-1:0] next_q  [SIZE_CLASSES];
  logic [ADDR_W-1:0] next_d  [SIZE_CLASSES];
  logic [LeftW-1:0]  left_q  [SIZE_CLASSES];
  logic [LeftW-1:0]  left_d  [SIZE_CLASSES];
  logic [LeftW-1:0]  carve_init [SIZE_CLASSES];
  logic [UsedW-1:0]  used_q, used_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [ClsW-1:0]   pop_cls_q, pop_cls_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  status_e           out_status_q, out_status_d;

  logic              take, out_free;
  logic [ClsW-1:0]   cls;
  logic [LINK_W-1:0] head;
  logic [ADDR_W-1:0] cls_bytes;
  logic              link_we, link_re;
  logic [LINK_W-1:0] link_rdata;

  // blocks per chunk for each class, less the one handed out on opening
  for (genvar g = 0; g < SIZE_CLASSES; g++) begin : g_carve
    localparam int Cnt = CHUNK_BYTES / int'(CLASS_BYTES[g]);
    assign carve_init[g] = LeftW'(Cnt - 1);
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign job_ready_o = (state_q == ST_RUN) && out_free;
  assign take        = job_valid_i && job_ready_o;
  assign cls         = job_i.cls[ClsW-1:0];
  assign head        = heads_q[cls];
  assign cls_bytes   = ADDR_W'(CLASS_BYTES[cls]);

  scba_ram #(
    .WIDTH (LINK_W),
    .DEPTH (LINK_DEPTH)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (job_i.address[ADDR_W-1:SLOT_SHIFT]),
    .wdata_i (head),
    .re_i    (link_re),
    .raddr_i (head[ADDR_W-1:SLOT_SHIFT]),
    .rdata_o (link_rdata)
  );

  always_comb begin
    state_d      = state_q;
    heads_d      = heads_q;
    next_d       = next_q;
    left_d       = left_q;
    used_d       = used_q;
    base_d       = base_q;
    pop_cls_d    = pop_cls_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    link_we      = 1'b0;
    link_re      = 1'b0;
    case (state_q)
      ST_RUN: begin
        if (take) begin
          out_valid_d  = 1'b1;
          out_addr_d   = '0;
          out_status_d = job_i.status;
          case (job_i.op)
            OP_ALLOC: begin
              if (head[ADDR_W]) begin
                // head goes out now, its link lands next cycle
                out_addr_d = head[ADDR_W-1:0];
                link_re    = 1'b1;
                pop_cls_d  = cls;
                state_d    = ST_POP;
              end else if (left_q[cls] != '0) begin
                out_addr_d  = next_q[cls];
                next_d[cls] = next_q[cls] + cls_bytes;
                left_d[cls] = left_q[cls] - LeftW'(1);
              end else if (used_q >= UsedW'(MAX_CHUNKS)) begin
                out_status_d = STATUS_NO_CHUNK;
              end else begin
                out_addr_d  = base_q;
                next_d[cls] = base_q + cls_bytes;
                left_d[cls] = carve_init[cls];
                used_d      = used_q + UsedW'(1);
                base_d      = base_q + ChunkStep;
              end
            end
            OP_FREE: begin
              link_we      = 1'b1;
              heads_d[cls] = {1'b1, job_i.address};
            end
            OP_CLEAR: begin
              for (int i = 0; i < SIZE_CLASSES; i++) begin
                heads_d[i] = '0;
                next_d[i]  = '0;
                left_d[i]  = '0;
              end
              used_d = '0;
              base_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        heads_d[pop_cls_q] = link_rdata;
        state_d            = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      used_q      <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SIZE_CLASSES; i++) begin
        heads_q[i] <= '0;
        next_q[i]  <= '0;
        left_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
      heads_q     <= heads_d;
      next_q      <= next_d;
      left_q      <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_cls_q    <= pop_cls_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = out_addr_q;
  assign out_status_o = out_status_q;

`ifndef NO_ASSERTIONS
  a_pop_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POP |=> state_q == ST_RUN)
    else $error("pop state held more than one cycle");

  a_pop_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POP |-> out_valid_q)
    else $error("popped block not presented");

  a_chunks_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(MAX_CHUNKS))
    else $error("chunk count beyond limit");

  a_link_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(link_we && link_re))
    else $error("link read and write in one cycle");
`endif

endmodule

/* dv/tb_size_class_block_allocator.sv */
module tb_size_class_block_allocator;
  import scba_pkg::*;

  localparam int MAX_CHUNKS  = 64;
  localparam int CHUNK_BYTES = 16384;
  localparam int MAX_BLOCK   = 640;
  localparam int FILL_LIMIT  = 830;
  localparam int CHURN_ITEMS = 500;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_e           status;
  } reply_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } block_t;

  // Mirror of the allocator: free lists, carving pointers and chunk count.
  class heap_scoreboard;
    logic [LINK_W-1:0] list_head [TABLE_LEN];
    logic [ADDR_W-1:0] carve_ptr [TABLE_LEN];
    int                carve_cnt [TABLE_LEN];
    int                chunk_cnt;
    logic [LINK_W-1:0] link_mem [LINK_DEPTH];
    reply_t            pending_replies [$];
    int                error_cnt;
    int                cmd_hits [3];
    int                status_hits [4];
    int                pop_hits;

    function new();
      error_cnt = 0;
      pop_hits  = 0;
      cmd_hits    = '{default: 0};
      status_hits = '{default: 0};
      drop_heap();
    endfunction

    function void drop_heap();
      for (int i = 0; i < TABLE_LEN; i++) begin
        list_head[i] = '0;
        carve_ptr[i] = '0;
        carve_cnt[i] = 0;
      end
      chunk_cnt = 0;
    endfunction

    function int class_of(logic [SIZE_W-1:0] sz);
      if (sz > MAX_BLOCK) return -1;
      for (int i = 0; i < TABLE_LEN; i++)
        if (sz <= CLASS_BYTES[i]) return i;
      return -1;
    endfunction

    function reply_t note_command(cmd_e cmd, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] ad);
      reply_t r;
      int     cls;
      int     bs;
      r.addr   = '0;
      r.status = STATUS_OK;
      cls = class_of(sz);
      case (cmd)
        CMD_ALLOC: begin
          cmd_hits[0]++;
          if (sz == 0) begin
            r.status = STATUS_NULL;
          end else if (cls < 0) begin
            r.status = STATUS_OVERSIZE;
          end else if (list_head[cls][ADDR_W]) begin
            r.addr = list_head[cls][ADDR_W-1:0];
            list_head[cls] = link_mem[r.addr[ADDR_W-1:SLOT_SHIFT]];
            pop_hits++;
          end else if (carve_cnt[cls] != 0) begin
            r.addr = carve_ptr[cls];
            carve_ptr[cls] = r.addr + CLASS_BYTES[cls];
            carve_cnt[cls]--;
          end else if (chunk_cnt >= MAX_CHUNKS) begin
            r.status = STATUS_NO_CHUNK;
          end else begin
            bs = CLASS_BYTES[cls];
            r.addr = ADDR_W'(chunk_cnt * CHUNK_BYTES);
            carve_ptr[cls] = r.addr + ADDR_W'(bs);
            carve_cnt[cls] = (CHUNK_BYTES / bs > 0) ? CHUNK_BYTES / bs - 1 : 0;
            chunk_cnt++;
          end
        end
        CMD_FREE: begin
          cmd_hits[1]++;
          if (sz == 0) begin
            r.status = STATUS_NULL;
          end else if (cls < 0) begin
            r.status = STATUS_OVERSIZE;
          end else begin
            link_mem[ad[ADDR_W-1:SLOT_SHIFT]] = list_head[cls];
            list_head[cls] = {1'b1, ad};
          end
        end
        CMD_CLEAR: begin
          cmd_hits[2]++;
          drop_heap();
        end
        default: ;
      endcase
      status_hits[r.status]++;
      pending_replies.push_back(r);
      return r;
    endfunction

    function void check_reply(logic [ADDR_W-1:0] addr, logic [STATUS_W-1:0] st);
      reply_t e;
      if (pending_replies.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("unexpected item: addr %05h status %0d", addr, st);
        return;
      end
      e = pending_replies.pop_front();
      if (e.addr !== addr || STATUS_W'(e.status) !== st) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("mismatch: expected addr %05h status %0d, got addr %05h status %0d",
                   e.addr, e.status, addr, st);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [CMD_W-1:0]     s_axis_tuser_i = CMD_ALLOC;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]  m_axis_tuser_o;

  heap_scoreboard heap_check;
  block_t         live_blocks [$];
  int             burst_left = 0;
  int             no_chunk_seen = 0;
  int             rdy_mode = 0;
  int             rdy_left = 0;
  logic [15:0]    rdy_mask = 16'h0001;

  size_class_block_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #4 clk_i = ~clk_i;

  // receiver: free-running, rotating stall mask, or sparse ready
  always @(posedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(16, 96);
      rdy_mask = 16'($urandom) | 16'h0001;
    end
    rdy_left--;
    rdy_mask = {rdy_mask[14:0], rdy_mask[15]};
    case (rdy_mode)
      2:       m_axis_tready_i <= rdy_mask[0];
      3:       m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      heap_check.check_reply(m_axis_tdata_o[ADDR_W-1:0], m_axis_tuser_o);
  end

  // Returns at the edge where the item is taken; tvalid is left high.
  task automatic send_item(input cmd_e cmd, input logic [SIZE_W-1:0] sz,
                           input logic [ADDR_W-1:0] ad, output reply_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {{(S_TDATA_W - ADDR_W - SIZE_W){1'b0}}, ad, sz};
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
    r = heap_check.note_command(cmd, sz, ad);
    if (r.status == STATUS_NO_CHUNK) no_chunk_seen++;
  endtask

  task automatic do_cmd(input cmd_e cmd, input logic [SIZE_W-1:0] sz,
                        input logic [ADDR_W-1:0] ad);
    reply_t r;
    send_item(cmd, sz, ad, r);
  endtask

  task automatic alloc_block(input logic [SIZE_W-1:0] sz);
    reply_t r;
    block_t b;
    send_item(CMD_ALLOC, sz, ADDR_W'($urandom), r);
    if (r.status == STATUS_OK) begin
      b.addr = r.addr;
      b.size = sz;
      live_blocks.push_back(b);
    end
  endtask

  task automatic churn_step();
    int                roll;
    int                idx;
    logic [SIZE_W-1:0] sz;
    block_t            b;
    roll = $urandom_range(0, 99);
    if (roll < 45 || (roll < 85 && live_blocks.size() == 0)) begin
      case ($urandom_range(0, 9))
        0:       sz = '0;
        1:       sz = SIZE_W'($urandom_range(MAX_BLOCK + 1, 16'hFFFF));
        2, 3: begin
          idx = $urandom_range(0, TABLE_LEN - 1);
          sz  = SIZE_W'(CLASS_BYTES[idx] + $urandom_range(0, 1));
        end
        4:       sz = SIZE_W'($urandom_range(1, 16));
        default: sz = SIZE_W'($urandom_range(1, MAX_BLOCK));
      endcase
      alloc_block(sz);
    end else if (roll < 85) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      b   = live_blocks[idx];
      live_blocks.delete(idx);
      // now and then the block goes back under a different class
      sz = ($urandom_range(0, 4) == 0) ? SIZE_W'($urandom_range(1, MAX_BLOCK)) : b.size;
      do_cmd(CMD_FREE, sz, b.addr);
    end else if (roll < 98) begin
      sz = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, MAX_BLOCK));
      do_cmd(CMD_FREE, sz, ADDR_W'($urandom));
    end else begin
      do_cmd(CMD_CLEAR, SIZE_W'($urandom), ADDR_W'($urandom));
      live_blocks.delete();
    end
  endtask

  initial begin
    int fill_cnt;
    heap_check = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // null and oversize on both commands
    do_cmd(CMD_ALLOC, 16'd0, 20'h00000);
    do_cmd(CMD_FREE, 16'd0, 20'h12345);
    do_cmd(CMD_ALLOC, 16'd641, 20'h00000);
    do_cmd(CMD_ALLOC, 16'hFFFF, 20'hFFFFF);
    do_cmd(CMD_FREE, 16'd641, 20'hABCDE);
    // chunk opening and carving
    do_cmd(CMD_ALLOC, 16'd1, 20'h00000);
    do_cmd(CMD_ALLOC, 16'd16, 20'h00000);
    do_cmd(CMD_ALLOC, 16'd17, 20'h00000);
    do_cmd(CMD_ALLOC, 16'd640, 20'h00000);
    // two pushes then two pops back to back, then carving resumes
    do_cmd(CMD_FREE, 16'd16, 20'h00000);
    do_cmd(CMD_FREE, 16'd10, 20'h00010);
    do_cmd(CMD_ALLOC, 16'd16, 20'h00000);
    do_cmd(CMD_ALLOC, 16'd16, 20'h00000);
    do_cmd(CMD_ALLOC, 16'd16, 20'h00000);
    // unaligned top address
    do_cmd(CMD_FREE, 16'd1, 20'hFFFFF);
    do_cmd(CMD_ALLOC, 16'd9, 20'h00000);
    do_cmd(CMD_FREE, 16'd640, 20'h08000);
    do_cmd(CMD_ALLOC, 16'd513, 20'h00000);
    do_cmd(CMD_CLEAR, 16'd0, 20'h00000);
    do_cmd(CMD_ALLOC, 16'd640, 20'h00000);
    do_cmd(CMD_ALLOC, 16'd512, 20'h00000);
    do_cmd(CMD_FREE, 16'd33, 20'h00007);
    do_cmd(CMD_ALLOC, 16'd64, 20'h00000);
    do_cmd(CMD_CLEAR, 16'hFFFF, 20'hFFFFF);

    // open many chunks with large blocks, stopping early if chunks run out
    fill_cnt = 0;
    while (no_chunk_seen < 4 && fill_cnt < FILL_LIMIT) begin
      if ($urandom_range(0, 99) < 92)
        alloc_block(SIZE_W'($urandom_range(513, MAX_BLOCK)));
      else
        churn_step();
      fill_cnt++;
    end

    // mixed traffic on top of the busy heap; frees feed deep lists
    repeat (CHURN_ITEMS) churn_step();

    s_axis_tvalid_i <= 1'b0;
    while (heap_check.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("items: %0d alloc, %0d free, %0d clear; %0d served from free lists",
             heap_check.cmd_hits[0], heap_check.cmd_hits[1], heap_check.cmd_hits[2],
             heap_check.pop_hits);
    $display("replies: %0d ok, %0d null, %0d oversize, %0d out of chunks; %0d errors",
             heap_check.status_hits[0], heap_check.status_hits[1],
             heap_check.status_hits[2], heap_check.status_hits[3], heap_check.error_cnt);
    if (heap_check.error_cnt == 0 && heap_check.pending_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/scba_pkg.sv
src/scba_ram.sv
src/scba_front.sv
src/scba_queue.sv
src/scba_back.sv
src/size_class_block_allocator.sv
dv/tb_size_class_block_allocator.sv
